/* rtl/sobel_pkg.sv */
package sobel_pkg;

	localparam int MaxWidth = 1024;
	localparam int ColW = $clog2(MaxWidth);
	localparam int CfgWidthW = 11;
	localparam int CfgHeightW = 13;
	localparam int RowW = 13;
	localparam int PendW = ColW + 2;
	localparam int AddrW = 3;
	localparam logic [AddrW-1:0] RegWidth = 3'd0;
	localparam logic [AddrW-1:0] RegHeight = 3'd4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       drain;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] gray;
		logic       frame_last;
	} pix_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic is_drain;
		logic emit;
		logic use_win;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic busy;
		logic done;
	} dp_sts_t;

endpackage

/* rtl/sobel_root.sv */
module sobel_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] sq,
	output logic        done,
	output logic [7:0]  root
);
	import sobel_pkg::*;

	logic [7:0]  r_q;
	logic [3:0]  bit_q;
	logic [16:0] s_q;
	logic        run_q;
	logic        done_q;
	logic [7:0]  trial;
	logic [15:0] trial_sq;

	always_comb begin
		trial    = r_q | (8'd1 << bit_q[2:0]);
		trial_sq = trial * trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= ~sq[16];
				done_q <= sq[16];
				bit_q <= 4'd7;
			end else if (run_q) begin
				if (bit_q == 4'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				bit_q <= bit_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= sq;
			r_q <= sq[16] ? 8'd255 : 8'd0;
		end else if (run_q && {1'b0, trial_sq} <= s_q) begin
			r_q <= trial;
		end
	end

	assign done = done_q;
	assign root = r_q;
endmodule

/* rtl/sobel_dp.sv */
module sobel_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sobel_pkg::dp_cmd_t  cmd,
	input  sobel_pkg::pix_in_t  pix,
	input  logic [23:0]         up_rd,
	input  logic [23:0]         mid_rd,
	input  logic                out_last,
	output sobel_pkg::dp_sts_t  sts,
	output logic [7:0]          gray
);
	import sobel_pkg::*;

	logic [23:0] win_q [9];
	logic [1:0]  ch_q;
	logic        run_q;
	logic        wait_q;
	logic        start;
	logic [9:0]  sum_q;
	logic        done_q;
	logic [7:0]  gray_q;
	logic signed [11:0] gx, gy;
	logic [16:0] sq_s1;
	logic        sq_v_s1;
	logic        rdone;
	logic [7:0]  root;
	logic [7:0]  v [9];
	logic [21:0] sqsum;
	logic [19:0] prod;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			case (ch_q)
				2'd0: v[k] = win_q[k][23:16];
				2'd1: v[k] = win_q[k][15:8];
				default: v[k] = win_q[k][7:0];
			endcase
		end
		gx = $signed({4'd0, v[2]}) - $signed({4'd0, v[0]})
			+ $signed({3'd0, v[5], 1'b0}) - $signed({3'd0, v[3], 1'b0})
			+ $signed({4'd0, v[8]}) - $signed({4'd0, v[6]});
		gy = $signed({4'd0, v[6]}) - $signed({4'd0, v[0]})
			+ $signed({3'd0, v[7], 1'b0}) - $signed({3'd0, v[1], 1'b0})
			+ $signed({4'd0, v[8]}) - $signed({4'd0, v[2]});
		sqsum = 22'(gx * gx) + 22'(gy * gy);
		// divide by 3 as *683 >> 11, exact for sums up to 765
		prod = 20'(sum_q + {2'd0, root}) * 20'd683;
	end

	// window: index row*3+col, col 2 newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else if (cmd.load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= {pix.red, pix.green, pix.blue};
		end
	end

	assign start = run_q && !wait_q && !sq_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			wait_q  <= 1'b0;
			ch_q    <= 2'd0;
			done_q  <= 1'b0;
			sq_v_s1 <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			sq_v_s1 <= start;
			if (cmd.emit && !cmd.use_win) begin
				done_q <= 1'b1;
			end else if (cmd.emit) begin
				run_q <= 1'b1;
				ch_q  <= 2'd0;
			end else if (start) begin
				wait_q <= 1'b1;
			end else if (rdone) begin
				wait_q <= 1'b0;
				if (ch_q == 2'd2) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					ch_q <= ch_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) sq_s1 <= (sqsum >= 22'd65536) ? 17'h10000 : sqsum[16:0];
		if (cmd.emit) sum_q <= '0;
		else if (rdone) sum_q <= sum_q + {2'd0, root};
		if (cmd.emit && !cmd.use_win) gray_q <= '0;
		else if (rdone && ch_q == 2'd2) gray_q <= prod[18:11];
	end

	sobel_root u_root (
		.clk(clk), .arst_n(arst_n), .start(sq_v_s1), .sq(sq_s1),
		.done(rdone), .root(root)
	);

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign gray = gray_q;

	logic unused;
	assign unused = out_last ^ pix.drain ^ cmd.is_drain;
endmodule

/* rtl/sobel_ctrl.sv */
module sobel_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                drain,
	input  logic                out_free,
	input  logic                pend_emit,
	input  logic                pend_any,
	input  logic                aligned,
	input  sobel_pkg::dp_sts_t  sts,
	output sobel_pkg::dp_cmd_t  cmd,
	output logic                publish
);
	import sobel_pkg::*;

	typedef enum logic [3:0] {
		IDLE = 4'b0001,
		LOAD = 4'b0010,
		CALC = 4'b0100,
		PUSH = 4'b1000
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == IDLE) && in_valid && !drain;
		cmd.is_drain = drain;
		cmd.emit = (state_q == IDLE) && in_valid &&
			(drain ? pend_any : pend_emit);
		cmd.use_win = !drain && aligned;
	end

	assign publish = (state_q == PUSH) && out_free;

	// LOAD lets the line buffer read the next column before the next transfer is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd.emit) state_q <= CALC;
					else if (cmd.load) state_q <= LOAD;
				end
				LOAD: state_q <= IDLE;
				CALC: if (sts.done) state_q <= PUSH;
				PUSH: if (out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CALC && sts.done |=> state_q == PUSH)
		else $error("done lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == CALC)
		else $error("emit not followed");
	assert property (@(posedge clk) disable iff (!arst_n)
		publish |-> state_q == PUSH)
		else $error("bad publish");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == LOAD |=> state_q == IDLE)
		else $error("load stuck");
endmodule

/* rtl/sobel_edge_rgb_to_gray.sv */
// Sobel edge detector, RGB in, gray out.
// Input channel (in_valid/in_ready, in_data): raster-order pixels; drain=1
//   carries no pixel and flushes one pending result.
// Output channel (out_valid/out_ready, out_data): gray magnitude and
//   frame_last. Result for pixel k comes with input k+width+1 (or a drain).
// APB port: image_width at 0x0, image_height at 0x4; write only when idle.
// Sequence: a drain with nothing pending is taken in IDLE alone, a pixel with
//   no result passes through LOAD for the line buffer read. An item with a
//   result passes through CALC: three channels pass one at a time through a
//   bit-serial integer square root (cut short when the square sum saturates),
//   then the result is registered in PUSH. A drain or border result skips
//   the square root.
// Throughput: one item at a time; the next transfer is taken once the result
//   is registered.
// Reset: counters, window and pending count clear; width 640, height 480.
//   Line buffers are not cleared.
// Stall: the output register holds a result until taken; the block keeps
//   computing the next one and waits only if the register is still full.
module sobel_edge_rgb_to_gray (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sobel_pkg::pix_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sobel_pkg::pix_out_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import sobel_pkg::*;

	logic [CfgWidthW-1:0]  width_q;
	logic [CfgHeightW-1:0] height_q;
	logic [23:0] upper_mem [MaxWidth];
	logic [23:0] middle_mem [MaxWidth];
	logic [ColW:0] in_col_q, out_col_q;
	logic [RowW-1:0] in_row_q, out_row_q;
	logic [PendW-1:0] pend_q;
	logic [ColW:0] w_eff;
	logic [RowW-1:0] h_eff;
	logic [ColW-1:0] c_idx;
	logic [23:0] up_rd, mid_rd;
	logic [23:0] up_rd_q, mid_rd_q;
	logic aligned, pend_emit, pend_any, out_free, publish;
	logic interior_q, last_q;
	logic out_valid_q;
	pix_out_t out_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [7:0] gray;
	logic in_fire, emit_last, out_interior, wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
		end else if (wr) begin
			unique case (paddr)
				RegWidth:  width_q <= pwdata[CfgWidthW-1:0];
				RegHeight: height_q <= pwdata[CfgHeightW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			RegWidth:  prdata = {21'd0, width_q};
			RegHeight: prdata = {19'd0, height_q};
			default:   prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) w_eff = (ColW+1)'(1);
		else if (width_q > CfgWidthW'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
		else w_eff = (ColW+1)'(width_q);
		h_eff = (height_q == '0) ? RowW'(1) : height_q;
	end

	assign in_fire = in_valid && in_ready;
	assign c_idx = in_col_q[ColW] ? '0 : in_col_q[ColW-1:0];

	// line buffers: registered read of the current column, ready in the cycle
	// after the column moves; the write reuses the registered middle entry
	always_ff @(posedge clk) begin
		if (in_fire && !in_data.drain) begin
			upper_mem[c_idx]  <= mid_rd_q;
			middle_mem[c_idx] <= {in_data.red, in_data.green, in_data.blue};
		end
		up_rd_q  <= upper_mem[c_idx];
		mid_rd_q <= middle_mem[c_idx];
	end
	assign up_rd = up_rd_q;
	assign mid_rd = mid_rd_q;

	assign aligned = (in_row_q == out_row_q + RowW'(1)) &&
		(in_col_q == out_col_q + (ColW+1)'(1));
	assign pend_emit = ({1'b0, pend_q} + (PendW+1)'(1)) > (PendW+1)'(w_eff) + (PendW+1)'(1);
	assign pend_any = pend_q != '0;
	assign emit_last = (out_row_q + RowW'(1) >= h_eff) &&
		(out_col_q + (ColW+1)'(1) >= w_eff);
	assign out_interior = out_row_q >= RowW'(1) && out_row_q + RowW'(1) < h_eff &&
		out_col_q >= (ColW+1)'(1) && out_col_q + (ColW+1)'(1) < w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (in_fire) begin
			if (!in_data.drain) begin
				if (in_col_q + (ColW+1)'(1) >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= (in_row_q + RowW'(1) >= h_eff) ? '0 : in_row_q + RowW'(1);
				end else begin
					in_col_q <= in_col_q + (ColW+1)'(1);
				end
			end
			if (cmd.emit) begin
				if (out_col_q + (ColW+1)'(1) >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= emit_last ? '0 : out_row_q + RowW'(1);
				end else begin
					out_col_q <= out_col_q + (ColW+1)'(1);
				end
			end
			if (!in_data.drain && !cmd.emit) pend_q <= pend_q + PendW'(1);
			else if (in_data.drain && cmd.emit) pend_q <= pend_q - PendW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q     <= emit_last;
			interior_q <= out_interior;
		end
	end

	dp_cmd_t dcmd;
	always_comb begin
		dcmd = cmd;
		dcmd.use_win = cmd.use_win && out_interior;
	end

	sobel_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.drain(in_data.drain), .out_free(out_free), .pend_emit(pend_emit),
		.pend_any(pend_any), .aligned(aligned), .sts(sts), .cmd(cmd),
		.publish(publish)
	);

	sobel_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd), .pix(in_data), .up_rd(up_rd),
		.mid_rd(mid_rd), .out_last(last_q), .sts(sts), .gray(gray)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (publish) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (publish) begin
			out_q.gray       <= interior_q ? gray : 8'd0;
			out_q.frame_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> in_fire)
		else $error("emit without transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.drain && !pend_any |=> $stable(pend_q))
		else $error("empty drain moved count");
endmodule
